### hw/rtl/tap_pkg.sv
// Package for the triangle area and perimeter block.
// Holds side and result widths, saturation limits and the item structs.
// No dependencies.
package tap_pkg;

    localparam int SIDE_BITS  = 16;
    localparam int PERIM_BITS = 18;
    localparam int AREA_BITS  = 31;

    localparam logic [PERIM_BITS-1:0] PERIM_MAX = '1;
    localparam logic [AREA_BITS-1:0]  AREA_MAX  = '1;

    typedef struct packed {
        logic [SIDE_BITS-1:0] side_a;
        logic [SIDE_BITS-1:0] side_b;
        logic [SIDE_BITS-1:0] side_c;
    } tap_in_t;

    typedef struct packed {
        logic                  valid_res;
        logic [PERIM_BITS-1:0] perimeter;
        logic [AREA_BITS-1:0]  area;
    } tap_out_t;

endpackage

### hw/rtl/triangle_area_perimeter.sv
// Top level of the triangle area and perimeter block (Heron formula).
// Depends on tap_pkg for widths, limits and the in/out item structs.
//
//   channel | ports                 | handshake
//   --------+-----------------------+------------------------------------
//   input   | start, busy, sides    | item taken when start && !busy
//   result  | done, result          | one-cycle strobe, cannot be held off
//
// Pipeline: one item enters per clock. Each item passes the sum stage, two
// multiply stages and a reduce stage, then the square-root pipeline, one
// root bit per stage over RW stages, and last the output stage, which
// registers done and result.
// Reset: rst_n clears all valid bits; payload registers are not reset.
// Stalls: the receiver cannot stall, so the pipeline always advances and
// busy stays low.
module triangle_area_perimeter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tap_pkg::tap_in_t sides,
    output logic             done,
    output tap_pkg::tap_out_t result
);
    import tap_pkg::*;

    // Widths, all derived from the side width.
    localparam int SW  = SIDE_BITS + 2;      // sum, signed pairwise difference
    localparam int DW  = SIDE_BITS + 1;      // magnitude of a valid difference
    localparam int P1W = SW + DW;            // s * (b+c-a)
    localparam int P2W = 2 * DW;             // (a+c-b) * (a+b-c)
    localparam int H   = (P1W + 1) / 2;      // split point of the wide product
    localparam int P1HW = P1W - H;
    localparam int P2HW = P2W - H;
    localparam int PW  = P1W + P2W;          // full Heron product
    localparam int RW  = (PW + 1) / 2;       // root width
    localparam int TW  = 2 * RW;             // remainder / trial width

    // Nothing ever holds the pipeline back.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: sum and pairwise differences, nonzero check.
    // A difference that went negative shows up in its top bit.
    // ------------------------------------------------------------------
    logic          vld1_reg;
    logic          nz1_reg;
    logic [SW-1:0] s1_reg;
    logic [SW-1:0] d1_reg, d2_reg, d3_reg;

    logic [SW-1:0] a_ext, b_ext, c_ext;
    assign a_ext = SW'(sides.side_a);
    assign b_ext = SW'(sides.side_b);
    assign c_ext = SW'(sides.side_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        nz1_reg <= (sides.side_a != '0) && (sides.side_b != '0) && (sides.side_c != '0);
        s1_reg  <= a_ext + b_ext + c_ext;
        d1_reg  <= b_ext + c_ext - a_ext;
        d2_reg  <= a_ext + c_ext - b_ext;
        d3_reg  <= a_ext + b_ext - c_ext;
    end

    // ------------------------------------------------------------------
    // Stage 2: triangle check and the two half products.
    // ------------------------------------------------------------------
    logic           vld2_reg;
    logic           ok2_reg;
    logic [SW-1:0]  s2_reg;
    logic [P1W-1:0] p1_reg;
    logic [P2W-1:0] p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok2_reg <= nz1_reg && !d1_reg[SW-1] && !d2_reg[SW-1] && !d3_reg[SW-1];
        s2_reg  <= s1_reg;
        p1_reg  <= P1W'(s1_reg) * P1W'(d1_reg[DW-1:0]);
        p2_reg  <= P2W'(d2_reg[DW-1:0]) * P2W'(d3_reg[DW-1:0]);
    end

    // ------------------------------------------------------------------
    // Stage 3: four partial products of p1 * p2.
    // ------------------------------------------------------------------
    logic                 vld3_reg;
    logic                 ok3_reg;
    logic [SW-1:0]        s3_reg;
    logic [2*H-1:0]       pll_reg;
    logic [H+P2HW-1:0]    plh_reg;
    logic [P1HW+H-1:0]    phl_reg;
    logic [P1HW+P2HW-1:0] phh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok3_reg <= ok2_reg;
        s3_reg  <= s2_reg;
        pll_reg <= (2*H)'(p1_reg[H-1:0]) * (2*H)'(p2_reg[H-1:0]);
        plh_reg <= (H+P2HW)'(p1_reg[H-1:0]) * (H+P2HW)'(p2_reg[P2W-1:H]);
        phl_reg <= (P1HW+H)'(p1_reg[P1W-1:H]) * (P1HW+H)'(p2_reg[H-1:0]);
        phh_reg <= (P1HW+P2HW)'(p1_reg[P1W-1:H]) * (P1HW+P2HW)'(p2_reg[P2W-1:H]);
    end

    // ------------------------------------------------------------------
    // Stage 4 onward: reduce the partial products into the root pipeline,
    // then one root bit per stage (restoring digit-by-digit square root).
    // Entry 0 of each array is the reduced product; entry RW the result.
    // ------------------------------------------------------------------
    logic          sq_vld_reg [0:RW];
    logic          sq_ok_reg  [0:RW];
    logic [SW-1:0] sq_s_reg   [0:RW];
    logic [TW-1:0] sq_rem_reg [0:RW];
    logic [RW-1:0] sq_q_reg   [0:RW];

    logic [TW-1:0] prod_next;
    assign prod_next = (TW'(phh_reg) << (2*H))
                     + ((TW'(plh_reg) + TW'(phl_reg)) << H)
                     + TW'(pll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else
        begin
            sq_vld_reg[0] <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_ok_reg[0]  <= ok3_reg;
        sq_s_reg[0]   <= s3_reg;
        sq_rem_reg[0] <= prod_next;
        sq_q_reg[0]   <= '0;
    end

    for (genvar gi = 0; gi < RW; gi++)
    begin : g_root
        localparam int K = RW - 1 - gi;   // root bit decided in this stage

        logic [TW-1:0] trial;
        logic          take;
        logic [TW-1:0] rem_next;
        logic [RW-1:0] q_next;

        // (q + 2^K)^2 - q^2 = q * 2^(K+1) + 2^(2K)
        assign trial    = (TW'(sq_q_reg[gi]) << (K + 1)) | (TW'(1) << (2 * K));
        assign take     = sq_rem_reg[gi] >= trial;
        assign rem_next = take ? (sq_rem_reg[gi] - trial) : sq_rem_reg[gi];
        assign q_next   = take ? (sq_q_reg[gi] | (RW'(1) << K)) : sq_q_reg[gi];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[gi+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[gi+1] <= sq_vld_reg[gi];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_ok_reg[gi+1]  <= sq_ok_reg[gi];
            sq_s_reg[gi+1]   <= sq_s_reg[gi];
            sq_rem_reg[gi+1] <= rem_next;
            sq_q_reg[gi+1]   <= q_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: divide the root by four, saturate, zero on a bad item.
    // ------------------------------------------------------------------
    logic [RW-1:0] area_raw;
    tap_out_t      result_next;
    logic          done_reg;
    tap_out_t      result_reg;

    assign area_raw = sq_q_reg[RW] >> 2;

    always_comb
    begin
        result_next = '0;
        if (sq_ok_reg[RW])
        begin
            result_next.valid_res = 1'b1;
            if (32'(sq_s_reg[RW]) > 32'(PERIM_MAX))
            begin
                result_next.perimeter = PERIM_MAX;
            end
            else
            begin
                result_next.perimeter = PERIM_BITS'(sq_s_reg[RW]);
            end
            if (64'(area_raw) > 64'(AREA_MAX))
            begin
                result_next.area = AREA_MAX;
            end
            else
            begin
                result_next.area = AREA_BITS'(area_raw);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sq_vld_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
